// ===== design/stepped_line_point_generator_unit_defines.svh =====
// Assertion macros for the stepped line point generator checker.
// Needs nothing else; included by the checker file only.
`ifndef STEPPED_LINE_POINT_GENERATOR_UNIT_DEFINES_SVH
`define STEPPED_LINE_POINT_GENERATOR_UNIT_DEFINES_SVH

// Same-cycle implication, held off while reset is low.
`define SLPG_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is low.
`define SLPG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/slpg_pkg.sv =====
// Shared constants for the stepped line point generator.
// No dependencies; used by the top level and its checker.
package slpg_pkg;

    localparam int FRAC_BITS = 4;
    localparam int INT_BITS  = 10;
    localparam int STEP_W    = 10;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_NEXT = 1'b1;

endpackage

// ===== design/slpg_mul.sv =====
// Registered signed multiplier shared by the load and next-point paths.
// No package dependencies.
module slpg_mul #(
    parameter int A_W = 15
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [A_W-1:0]   i_a,
    input  logic signed [A_W-1:0]   i_b,
    output logic signed [2*A_W-1:0] o_p
);

    logic signed [2*A_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= i_a * i_b;
        end
    end

    assign o_p = r_p;

endmodule

// ===== design/slpg_div.sv =====
// Restoring divider: one quotient bit per cycle by compare and subtract.
// No package dependencies; the quotient must fit in Q_W bits.
module slpg_div #(
    parameter int NUM_W = 30,
    parameter int DEN_W = 19,
    parameter int Q_W   = 11
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [Q_W-1:0]   o_quot
);

    localparam int CNT_W = $clog2(Q_W + 1);

    logic [NUM_W-1:0] r_rem;
    logic [NUM_W-1:0] r_den_sh;
    logic [Q_W-1:0]   r_q;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic [NUM_W:0]   w_sub;
    logic             w_ge;

    assign w_sub = {1'b0, r_rem} - {1'b0, r_den_sh};
    assign w_ge  = !w_sub[NUM_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= CNT_W'(Q_W);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem    <= i_num;
            r_den_sh <= NUM_W'(i_den) << (Q_W - 1);
            r_q      <= '0;
        end else if (r_cnt != '0) begin
            // take the difference as the new partial remainder when the shifted divisor fits
            if (w_ge) begin
                r_rem <= w_sub[NUM_W-1:0];
            end
            r_q      <= {r_q[Q_W-2:0], w_ge};
            r_den_sh <= r_den_sh >> 1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== design/stepped_line_point_generator_unit.sv =====
// Stepped line point generator: loads a line, then hands out at most one point per next word.
// Depends on slpg_pkg, slpg_mul and slpg_div.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+----------------------------------
//  cfg     | in        | i_cfg_we                  | i_cfg_wdata (step width)
//  in      | in        | i_in_valid / o_in_stall   | i_cmd, i_x_a, i_y_a, i_x_b, i_y_b
//  out     | out       | o_out_valid / i_out_stall | o_px, o_py, o_point_valid, o_last_point
//
// A load word passes through S_BASE, where the base of the numerator is formed, and gives no output word.
// A next word on a vertical or exhausted line gives its output word in the following cycle.
// A next word on a sloped line goes through S_NUM, then S_DIV, where the divider produces one bit
// of y per cycle; S_DIV gives the output word once the output side is free.
// Reset is synchronous and active low; it leaves the walk exhausted with step 1.
// A stalled output word holds; o_in_stall stays high while it is stuck.
module stepped_line_point_generator_unit #(
    parameter int FRAC_BITS = slpg_pkg::FRAC_BITS,
    parameter int INT_BITS  = slpg_pkg::INT_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [slpg_pkg::STEP_W-1:0]       i_cfg_wdata,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_cmd,
    input  logic [INT_BITS+FRAC_BITS-1:0]     i_x_a,
    input  logic [INT_BITS+FRAC_BITS-1:0]     i_y_a,
    input  logic [INT_BITS+FRAC_BITS-1:0]     i_x_b,
    input  logic [INT_BITS+FRAC_BITS-1:0]     i_y_b,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [INT_BITS:0]                 o_px,
    output logic [INT_BITS:0]                 o_py,
    output logic                              o_point_valid,
    output logic                              o_last_point
);

    localparam int COORD_W = INT_BITS + FRAC_BITS;
    localparam int OUT_W   = INT_BITS + 1;
    localparam int STEP_W  = slpg_pkg::STEP_W;
    localparam int WALK_W  = ((COORD_W > STEP_W + FRAC_BITS) ? COORD_W
                                                             : STEP_W + FRAC_BITS) + 1;
    localparam int MUL_W   = COORD_W + 1;
    localparam int NUM_W   = 2 * COORD_W + 2;
    localparam int DEN_W   = COORD_W + FRAC_BITS + 1;
    localparam int VCMP_W  = WALK_W + FRAC_BITS;
    localparam logic [COORD_W:0] HALF = (COORD_W + 1)'((1 << FRAC_BITS) >> 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_BASE = 4'b0010,
        S_NUM  = 4'b0100,
        S_DIV  = 4'b1000
    } t_state;

    // half-up rounding of a fixed-point coordinate to whole pixels
    function automatic logic [OUT_W-1:0] f_round(input logic [COORD_W-1:0] v);
        logic [COORD_W:0] s;
        s = {1'b0, v} + HALF;
        return OUT_W'(s >> FRAC_BITS);
    endfunction

    // control state
    t_state           r_state, n_state;
    logic [STEP_W-1:0] r_step;
    logic             r_exh, n_exh;
    logic             r_out_valid, n_out_valid;

    // line state and payload
    logic [COORD_W-1:0] r_fx, n_fx, r_fy, n_fy, r_ex, n_ex, r_ey, n_ey;
    logic [WALK_W-1:0]  r_walk, n_walk;
    logic               r_vert, n_vert;
    logic [NUM_W-1:0]   r_base, n_base;
    logic [OUT_W-1:0]   r_hold_px, n_hold_px;
    logic               r_hold_last, n_hold_last;
    logic [OUT_W-1:0]   r_px, n_px, r_py, n_py;
    logic               r_pv, n_pv, r_last, n_last;

    // load-time endpoint ordering
    logic               w_xswap, w_yswap, w_ld_vert;
    logic [COORD_W-1:0] w_ld_fx, w_ld_ex, w_ld_fy0, w_ld_ey0, w_ld_fy, w_ld_ey;

    // walk arithmetic
    logic [STEP_W-1:0]  w_step;
    logic [COORD_W-1:0] w_dx;
    logic [WALK_W-1:0]  w_next_v, w_next_s;
    logic [VCMP_W-1:0]  w_vpos, w_vnext, w_vend;
    logic               w_v_past, w_v_last, w_s_past, w_s_last;

    // shared multiplier and divider
    logic                     w_acc, w_out_free, w_mul_en, w_div_start, w_div_done;
    logic signed [MUL_W-1:0]  w_mul_a, w_mul_b;
    logic signed [NUM_W-1:0]  w_prod;
    logic signed [NUM_W+1:0]  w_num_s;
    logic [NUM_W-1:0]         w_num;
    logic [DEN_W-1:0]         w_den;
    logic [OUT_W-1:0]         w_quot;

    assign o_in_stall = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign w_acc      = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // order the endpoints so x rises; a vertical line also gets rising y
    assign w_xswap   = i_x_a > i_x_b;
    assign w_ld_fx   = w_xswap ? i_x_b : i_x_a;
    assign w_ld_ex   = w_xswap ? i_x_a : i_x_b;
    assign w_ld_fy0  = w_xswap ? i_y_b : i_y_a;
    assign w_ld_ey0  = w_xswap ? i_y_a : i_y_b;
    assign w_ld_vert = w_ld_fx == w_ld_ex;
    assign w_yswap   = w_ld_vert && (w_ld_fy0 > w_ld_ey0);
    assign w_ld_fy   = w_yswap ? w_ld_ey0 : w_ld_fy0;
    assign w_ld_ey   = w_yswap ? w_ld_fy0 : w_ld_ey0;

    // a zero step acts as one
    assign w_step = (r_step == '0) ? STEP_W'(1) : r_step;
    assign w_dx   = r_ex - r_fx;

    // vertical walk: integer y compared against the fixed-point top
    assign w_next_v = r_walk + WALK_W'(w_step);
    assign w_vpos   = {r_walk, {FRAC_BITS{1'b0}}};
    assign w_vnext  = {w_next_v, {FRAC_BITS{1'b0}}};
    assign w_vend   = VCMP_W'(r_ey);
    assign w_v_past = w_vpos > w_vend;
    assign w_v_last = w_vnext > w_vend;

    // sloped walk: fixed-point x
    assign w_next_s = r_walk + (WALK_W'(w_step) << FRAC_BITS);
    assign w_s_past = r_walk > WALK_W'(r_ex);
    assign w_s_last = w_next_s > WALK_W'(r_ex);

    // multiplier operands: y1*dx on load, (x - x1)*dy on a next word
    always_comb begin
        if (i_cmd == slpg_pkg::CMD_LOAD) begin
            w_mul_a = signed'({1'b0, w_ld_fy});
            w_mul_b = signed'({1'b0, w_ld_ex}) - signed'({1'b0, w_ld_fx});
        end else begin
            w_mul_a = signed'({1'b0, r_walk[COORD_W-1:0] - r_fx});
            w_mul_b = signed'({1'b0, r_ey}) - signed'({1'b0, r_fy});
        end
    end

    assign w_mul_en = w_acc;

    slpg_mul #(
        .A_W (MUL_W)
    ) u_mul (
        .i_clk (i_clk),
        .i_en  (w_mul_en),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    // numerator 2*(y1*dx + (x-x1)*dy) + dx*2^F; the line keeps it non-negative
    assign w_num_s = signed'({2'b00, r_base}) + ((NUM_W + 2)'(w_prod) <<< 1);
    assign w_num   = w_num_s[NUM_W-1:0];
    assign w_den   = DEN_W'(w_dx) << (FRAC_BITS + 1);

    slpg_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W),
        .Q_W   (OUT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_comb begin
        n_state     = r_state;
        n_exh       = r_exh;
        n_fx        = r_fx;
        n_fy        = r_fy;
        n_ex        = r_ex;
        n_ey        = r_ey;
        n_walk      = r_walk;
        n_vert      = r_vert;
        n_base      = r_base;
        n_hold_px   = r_hold_px;
        n_hold_last = r_hold_last;
        n_px        = r_px;
        n_py        = r_py;
        n_pv        = r_pv;
        n_last      = r_last;
        n_out_valid = r_out_valid && i_out_stall;
        w_div_start = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (i_cmd == slpg_pkg::CMD_LOAD) begin
                        n_fx    = w_ld_fx;
                        n_fy    = w_ld_fy;
                        n_ex    = w_ld_ex;
                        n_ey    = w_ld_ey;
                        n_vert  = w_ld_vert;
                        n_walk  = w_ld_vert ? WALK_W'(f_round(w_ld_fy)) : WALK_W'(w_ld_fx);
                        n_exh   = 1'b0;
                        n_state = S_BASE;
                    end else if (r_exh || (r_vert && w_v_past) || (!r_vert && w_s_past)) begin
                        // nothing left to plot: report an empty word
                        n_exh       = 1'b1;
                        n_out_valid = 1'b1;
                        n_px        = '0;
                        n_py        = '0;
                        n_pv        = 1'b0;
                        n_last      = 1'b0;
                    end else if (r_vert) begin
                        n_out_valid = 1'b1;
                        n_px        = f_round(r_fx);
                        n_py        = r_walk[OUT_W-1:0];
                        n_pv        = 1'b1;
                        n_last      = w_v_last;
                        n_walk      = w_next_v;
                        n_exh       = w_v_last;
                    end else begin
                        // sloped: hold x and the last flag while y is divided out
                        n_hold_px   = f_round(r_walk[COORD_W-1:0]);
                        n_hold_last = w_s_last;
                        n_walk      = w_next_s;
                        n_exh       = w_s_last;
                        n_state     = S_NUM;
                    end
                end
            end
            S_BASE: begin
                n_base  = (NUM_W'(unsigned'(w_prod)) << 1) + (NUM_W'(w_dx) << FRAC_BITS);
                n_state = S_IDLE;
            end
            S_NUM: begin
                w_div_start = 1'b1;
                n_state     = S_DIV;
            end
            S_DIV: begin
                if (w_div_done && w_out_free) begin
                    n_out_valid = 1'b1;
                    n_px        = r_hold_px;
                    n_py        = w_quot;
                    n_pv        = 1'b1;
                    n_last      = r_hold_last;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= STEP_W'(1);
            r_exh       <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_exh       <= n_exh;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_step <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fx        <= n_fx;
        r_fy        <= n_fy;
        r_ex        <= n_ex;
        r_ey        <= n_ey;
        r_walk      <= n_walk;
        r_vert      <= n_vert;
        r_base      <= n_base;
        r_hold_px   <= n_hold_px;
        r_hold_last <= n_hold_last;
        r_px        <= n_px;
        r_py        <= n_py;
        r_pv        <= n_pv;
        r_last      <= n_last;
    end

    assign o_out_valid   = r_out_valid;
    assign o_px          = r_px;
    assign o_py          = r_py;
    assign o_point_valid = r_pv;
    assign o_last_point  = r_last;

endmodule

// ===== design/slpg_checker.sv =====
// Port-level checks for the stepped line point generator, bound to the top level.
// Depends on slpg_pkg and stepped_line_point_generator_unit_defines.svh.
`include "stepped_line_point_generator_unit_defines.svh"

module slpg_checker #(
    parameter int P_OUT_W = slpg_pkg::INT_BITS + 1
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               i_cmd,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [P_OUT_W-1:0] o_px,
    input logic [P_OUT_W-1:0] o_py,
    input logic               o_point_valid,
    input logic               o_last_point
);

    `SLPG_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_px) && $stable(o_py) && $stable(o_point_valid) && $stable(o_last_point), "stalled output word changed")
    `SLPG_ASSERT_NOW(a_empty_zero, i_clk, i_rst_n, o_out_valid && !o_point_valid, o_px == '0 && o_py == '0 && !o_last_point, "empty word carries nonzero fields")
    `SLPG_ASSERT_NOW(a_last_has_point, i_clk, i_rst_n, o_out_valid && o_last_point, o_point_valid, "last flag without a point")
    `SLPG_ASSERT_NEXT(a_load_silent, i_clk, i_rst_n, i_in_valid && !o_in_stall && i_cmd == slpg_pkg::CMD_LOAD, !$rose(o_out_valid), "load word produced an output word")
    `SLPG_ASSERT_NOW(a_stall_back, i_clk, i_rst_n, o_out_valid && i_out_stall, o_in_stall, "input taken while output word is stuck")

endmodule

bind stepped_line_point_generator_unit slpg_checker #(
    .P_OUT_W (OUT_W)
) u_slpg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .i_cmd         (i_cmd),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_px          (o_px),
    .o_py          (o_py),
    .o_point_valid (o_point_valid),
    .o_last_point  (o_last_point)
);

// ===== bench/tb_top.sv =====
// Testbench for stepped_line_point_generator_unit: a directed table, then random line walks.
// Each output word is checked against a typed directed row's expected word or a line walker kept inside the bench.
// Depends on slpg_pkg and the design files of the unit; reads and writes no files.
module tb_top;
    import slpg_pkg::*;

    localparam int CW            = INT_BITS + FRAC_BITS;
    localparam int OW            = INT_BITS + 1;
    localparam int COORD_MAX     = (1 << CW) - 1;
    localparam int HALF          = (1 << FRAC_BITS) >> 1;
    // a load leaves no output word, so wait out its busy cycles before a register write
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES   = 300;
    // watchdog bound on the whole run
    localparam int CYCLE_LIMIT   = 400000;

    typedef logic [CW-1:0] coord_t;

    typedef struct packed {
        logic [OW-1:0] px;
        logic [OW-1:0] py;
        logic          point_valid;
        logic          last_point;
    } point_t;

    typedef enum logic {ROW_CFG, ROW_WORD} row_kind_e;

    typedef struct packed {
        row_kind_e         kind;
        logic [STEP_W-1:0] step;
        logic              cmd;
        coord_t            xa;
        coord_t            ya;
        coord_t            xb;
        coord_t            yb;
        logic              typed;
        point_t            want;
    } dir_row_t;

    localparam point_t NO_POINT = '0;
    localparam coord_t C_MAX    = '1;
    localparam int     N_DIR    = 28;

    // Directed rows. A typed row carries its expected word; the rest go to the walker.
    dir_row_t dir_tab [N_DIR] = '{
        // next right after reset: nothing loaded yet
        '{ROW_WORD, 10'd0, CMD_NEXT, 14'd0, 14'd0, 14'd0, 14'd0, 1'b1, NO_POINT},
        // single-pixel vertical line at the origin, then walk past it
        '{ROW_WORD, 10'd0, CMD_LOAD, 14'd0, 14'd0, 14'd0, 14'd0, 1'b0, NO_POINT},
        '{ROW_WORD, 10'd0, CMD_NEXT, 14'd0, 14'd0, 14'd0, 14'd0, 1'b1,
          '{11'd0, 11'd0, 1'b1, 1'b1}},
        '{ROW_WORD, 10'd0, CMD_NEXT, 14'd0, 14'd0, 14'd0, 14'd0, 1'b1, NO_POINT},
        // vertical line at y = 0.5: start rounds above the end, no points at all
        '{ROW_WORD, 10'd0, CMD_LOAD, 14'd16, 14'd8, 14'd16, 14'd8, 1'b0, NO_POINT},
        '{ROW_WORD, 10'd0, CMD_NEXT, 14'd0, 14'd0, 14'd0, 14'd0, 1'b1, NO_POINT},
        // widest step on the full diagonal, endpoints given high x first
        '{ROW_CFG, 10'd1023, CMD_LOAD, 14'd0, 14'd0, 14'd0, 14'd0, 1'b0, NO_POINT},
        '{ROW_WORD, 10'd0, CMD_LOAD, C_MAX, C_MAX, 14'd0, 14'd0, 1'b0, NO_POINT},
        '{ROW_WORD, 10'd0, CMD_NEXT, 14'd0, 14'd0, 14'd0, 14'd0, 1'b1,
          '{11'd0, 11'd0, 1'b1, 1'b0}},
        '{ROW_WORD, 10'd0, CMD_NEXT, C_MAX, C_MAX, C_MAX, C_MAX, 1'b0, NO_POINT},
        '{ROW_WORD, 10'd0, CMD_NEXT, 14'd0, 14'd0, 14'd0, 14'd0, 1'b1, NO_POINT},
        // vertical line at the right edge, y given high first
        '{ROW_WORD, 10'd0, CMD_LOAD, C_MAX, C_MAX, C_MAX, 14'd0, 1'b0, NO_POINT},
        '{ROW_WORD, 10'd0, CMD_NEXT, 14'd0, 14'd0, 14'd0, 14'd0, 1'b1,
          '{11'd1024, 11'd0, 1'b1, 1'b0}},
        '{ROW_WORD, 10'd0, CMD_NEXT, 14'd0, 14'd0, 14'd0, 14'd0, 1'b0, NO_POINT},
        '{ROW_WORD, 10'd0, CMD_NEXT, 14'd0, 14'd0, 14'd0, 14'd0, 1'b1, NO_POINT},
        // zero step acts as one: steep falling line, walk it out
        '{ROW_CFG, 10'd0, CMD_LOAD, 14'd0, 14'd0, 14'd0, 14'd0, 1'b0, NO_POINT},
        '{ROW_WORD, 10'd0, CMD_LOAD, 14'd40, 14'd200, 14'd8, C_MAX, 1'b0, NO_POINT},
        '{ROW_WORD, 10'd0, CMD_NEXT, 14'd0, 14'd0, 14'd0, 14'd0, 1'b0, NO_POINT},
        '{ROW_WORD, 10'd0, CMD_NEXT, 14'd0, 14'd0, 14'd0, 14'd0, 1'b0, NO_POINT},
        '{ROW_WORD, 10'd0, CMD_NEXT, 14'd0, 14'd0, 14'd0, 14'd0, 1'b0, NO_POINT},
        '{ROW_WORD, 10'd0, CMD_NEXT, 14'd0, 14'd0, 14'd0, 14'd0, 1'b0, NO_POINT},
        // short vertical line, then reload in mid walk
        '{ROW_WORD, 10'd0, CMD_LOAD, 14'd16, 14'd24, 14'd16, 14'd80, 1'b0, NO_POINT},
        '{ROW_WORD, 10'd0, CMD_NEXT, 14'd0, 14'd0, 14'd0, 14'd0, 1'b0, NO_POINT},
        '{ROW_WORD, 10'd0, CMD_NEXT, 14'd0, 14'd0, 14'd0, 14'd0, 1'b0, NO_POINT},
        '{ROW_WORD, 10'd0, CMD_LOAD, 14'd0, C_MAX, 14'd64, 14'd0, 1'b0, NO_POINT},
        '{ROW_WORD, 10'd0, CMD_NEXT, 14'd0, 14'd0, 14'd0, 14'd0, 1'b0, NO_POINT},
        '{ROW_WORD, 10'd0, CMD_NEXT, 14'd0, 14'd0, 14'd0, 14'd0, 1'b0, NO_POINT},
        '{ROW_CFG, 10'd1, CMD_LOAD, 14'd0, 14'd0, 14'd0, 14'd0, 1'b0, NO_POINT}
    };

    // DUT ports
    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [STEP_W-1:0] i_cfg_wdata;
    logic              i_in_valid;
    logic              o_in_stall;
    logic              i_cmd;
    coord_t            i_x_a;
    coord_t            i_y_a;
    coord_t            i_x_b;
    coord_t            i_y_b;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [OW-1:0]     o_px;
    logic [OW-1:0]     o_py;
    logic              o_point_valid;
    logic              o_last_point;

    // line walker state, mirrors the unit's registers
    coord_t            ln_x0;
    coord_t            ln_y0;
    coord_t            ln_x1;
    coord_t            ln_y1;
    logic [15:0]       ln_pos;
    logic              ln_vertical;
    logic              ln_exhausted;
    logic [STEP_W-1:0] step_width;

    point_t due_points [$];

    int n_err         = 0;
    int n_sent        = 0;
    int n_cycles      = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req_cnt  = 0;
    int hold_seen     = 0;
    int hold_left     = 0;

    stepped_line_point_generator_unit i_dut (
        .i_clk,
        .i_rst_n,
        .i_cfg_we,
        .i_cfg_wdata,
        .i_in_valid,
        .o_in_stall,
        .i_cmd,
        .i_x_a,
        .i_y_a,
        .i_x_b,
        .i_y_b,
        .o_out_valid,
        .i_out_stall,
        .o_px,
        .o_py,
        .o_point_valid,
        .o_last_point
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) n_cycles <= n_cycles + 1;

    // Round an unsigned fixed-point value to the nearest pixel, half up.
    function automatic logic [OW-1:0] round_half_up(input logic [15:0] v);
        logic [16:0] sum;
        sum = {1'b0, v} + 17'(HALF);
        return OW'(sum >> FRAC_BITS);
    endfunction

    // Exact rounded y of the loaded sloped line at fixed-point x.
    function automatic logic [OW-1:0] line_y_at(input logic [15:0] x);
        longint dx, dy, num, den;
        dx  = longint'(ln_x1) - longint'(ln_x0);
        dy  = longint'(ln_y1) - longint'(ln_y0);
        num = 2 * (longint'(ln_y0) * dx + (longint'(x) - longint'(ln_x0)) * dy)
              + dx * (longint'(1) << FRAC_BITS);
        den = 2 * dx * (longint'(1) << FRAC_BITS);
        if (num < 0 || den <= 0) return '0;
        return OW'(num / den);
    endfunction

    // Apply one accepted word to the walker; return 1 when it yields an output word.
    function automatic bit advance_walk(input logic cmd, input coord_t xa, input coord_t ya,
                                        input coord_t xb, input coord_t yb,
                                        output point_t pt);
        logic [31:0] nxt;
        logic [31:0] stride;
        coord_t      swap;
        pt = '0;
        if (cmd == CMD_LOAD) begin
            // order endpoints so x rises; vertical lines also get y rising
            if (xa > xb) {ln_x0, ln_y0, ln_x1, ln_y1} = {xb, yb, xa, ya};
            else         {ln_x0, ln_y0, ln_x1, ln_y1} = {xa, ya, xb, yb};
            ln_vertical = (ln_x0 == ln_x1);
            if (ln_vertical && ln_y0 > ln_y1) begin
                swap  = ln_y0;
                ln_y0 = ln_y1;
                ln_y1 = swap;
            end
            ln_pos       = ln_vertical ? 16'(round_half_up(16'(ln_y0))) : 16'(ln_x0);
            ln_exhausted = 1'b0;
            return 1'b0;
        end
        stride = (step_width == '0) ? 32'd1 : 32'(step_width);
        if (!ln_exhausted) begin
            if (ln_vertical) begin
                // walk position is an integer y here
                if ((32'(ln_pos) << FRAC_BITS) > 32'(ln_y1)) begin
                    ln_exhausted = 1'b1;
                end else begin
                    pt.point_valid = 1'b1;
                    pt.px          = round_half_up(16'(ln_x0));
                    pt.py          = OW'(ln_pos);
                    nxt            = 32'(ln_pos) + stride;
                    pt.last_point  = (nxt << FRAC_BITS) > 32'(ln_y1);
                    ln_pos         = 16'(nxt);
                end
            end else if (32'(ln_pos) > 32'(ln_x1)) begin
                ln_exhausted = 1'b1;
            end else begin
                pt.point_valid = 1'b1;
                pt.px          = round_half_up(ln_pos);
                pt.py          = line_y_at(ln_pos);
                nxt            = 32'(ln_pos) + (stride << FRAC_BITS);
                pt.last_point  = nxt > 32'(ln_x1);
                ln_pos         = 16'(nxt);
            end
            if (pt.last_point) ln_exhausted = 1'b1;
        end
        return 1'b1;
    endfunction

    // Offer one input word, hold it until accepted, then record what it should yield.
    task automatic send_word(input logic cmd, input coord_t xa, input coord_t ya,
                             input coord_t xb, input coord_t yb,
                             input bit typed = 1'b0, input point_t want = '0);
        point_t pt;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_x_a      <= xa;
        i_y_a      <= ya;
        i_x_b      <= xb;
        i_y_b      <= yb;
        do @(posedge i_clk); while (o_in_stall);
        n_sent++;
        if (advance_walk(cmd, xa, ya, xb, yb, pt)) due_points.push_back(typed ? want : pt);
    endtask

    // Next command; the endpoint fields carry noise the unit must ignore.
    task automatic ask_point();
        send_word(CMD_NEXT, coord_t'($urandom), coord_t'($urandom),
                  coord_t'($urandom), coord_t'($urandom));
    endtask

    // Drop valid and wait until every expected word is out and the unit is quiet.
    task automatic drain_points();
        i_in_valid <= 1'b0;
        while (due_points.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_step(input logic [STEP_W-1:0] value);
        drain_points();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        step_width   = value;
    endtask

    // Random line walks: mostly load-then-walk sequences, some stray and broken ones.
    task automatic run_lines(input int quota);
        int          stop_at, span, t, n;
        int unsigned pick;
        coord_t      xa, ya, xb, yb;
        stop_at = n_sent + quota;
        while (n_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 12) begin
                // stray word with random command and content
                send_word(1'($urandom_range(1)), coord_t'($urandom), coord_t'($urandom),
                          coord_t'($urandom), coord_t'($urandom));
            end else begin
                xa = coord_t'($urandom);
                ya = coord_t'($urandom);
                // mostly short spans so walks end within a few dozen points
                case ($urandom_range(9))
                    0, 1, 2, 3: span = $urandom_range(16 * 8);
                    4, 5, 6:    span = $urandom_range(16 * 48);
                    7:          span = 0;
                    default:    span = $urandom_range(COORD_MAX);
                endcase
                t = $urandom_range(1) ? int'(xa) + span : int'(xa) - span;
                if (t < 0) t = int'(xa) + span;
                if (t > COORD_MAX) t = int'(xa) - span;
                if (t < 0) t = 0;
                xb = coord_t'(t);
                if ($urandom_range(1)) begin
                    yb = coord_t'($urandom);
                end else begin
                    t  = int'(ya) + int'($urandom_range(16 * 16)) - 16 * 8;
                    yb = coord_t'(t < 0 ? 0 : (t > COORD_MAX ? COORD_MAX : t));
                end
                send_word(CMD_LOAD, xa, ya, xb, yb);
                if (pick < 18) continue;  // loaded but never walked
                if ($urandom_range(3) == 0) begin
                    // walk to the end and a little past it
                    n = 0;
                    while (!ln_exhausted && n < 48) begin
                        ask_point();
                        n++;
                    end
                    repeat ($urandom_range(2, 1)) ask_point();
                end else begin
                    repeat ($urandom_range(10, 1)) ask_point();
                end
            end
        end
    endtask

    // Output side: check every accepted word, then pick the stall for the next cycle.
    always @(posedge i_clk) begin
        point_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (due_points.size() == 0) begin
                $display("%0t: unexpected output word: expected none, got px=%0d py=%0d pv=%0b lp=%0b",
                         $time, o_px, o_py, o_point_valid, o_last_point);
                n_err++;
            end else begin
                want = due_points.pop_front();
                if (o_px !== want.px) begin
                    $display("%0t: px: expected %0d, got %0d", $time, want.px, o_px);
                    n_err++;
                end
                if (o_py !== want.py) begin
                    $display("%0t: py: expected %0d, got %0d", $time, want.py, o_py);
                    n_err++;
                end
                if (o_point_valid !== want.point_valid) begin
                    $display("%0t: point_valid: expected %0b, got %0b",
                             $time, want.point_valid, o_point_valid);
                    n_err++;
                end
                if (o_last_point !== want.last_point) begin
                    $display("%0t: last_point: expected %0b, got %0b",
                             $time, want.last_point, o_last_point);
                    n_err++;
                end
            end
        end
        // a new hold request starts a long stall counted here
        if (hold_req_cnt != hold_seen) begin
            hold_seen = hold_req_cnt;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'($urandom_range(99) < recv_idle_pct);
        end
    end

    // Stimulus
    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        i_in_valid  <= 1'b0;
        i_cmd       <= CMD_LOAD;
        i_x_a       <= '0;
        i_y_a       <= '0;
        i_x_b       <= '0;
        i_y_b       <= '0;
        // walker reset: nothing loaded, step 1
        step_width   = STEP_W'(1);
        ln_x0        = '0;
        ln_y0        = '0;
        ln_x1        = '0;
        ln_y1        = '0;
        ln_pos       = '0;
        ln_vertical  = 1'b0;
        ln_exhausted = 1'b1;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sender idles less than the receiver
        send_idle_pct = 28;
        recv_idle_pct = 45;
        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_CFG) begin
                write_step(dir_tab[i].step);
            end else begin
                send_word(dir_tab[i].cmd, dir_tab[i].xa, dir_tab[i].ya, dir_tab[i].xb,
                          dir_tab[i].yb, dir_tab[i].typed, dir_tab[i].want);
            end
        end
        run_lines(180);
        // hold the receiver off while words keep coming, so the unit backs up
        hold_req_cnt <= hold_req_cnt + 1;
        run_lines(60);
        // pause the sender until every word is out
        drain_points();
        run_lines(60);
        write_step(STEP_W'(3));
        run_lines(200);
        write_step(STEP_W'(0));
        run_lines(200);

        // receiver idles less than the sender
        send_idle_pct = 45;
        recv_idle_pct = 28;
        write_step(STEP_W'(1023));
        run_lines(180);
        hold_req_cnt <= hold_req_cnt + 1;
        run_lines(60);
        write_step(STEP_W'($urandom_range(1022, 2)));
        run_lines(200);

        // no idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_step(STEP_W'(2));
        run_lines(200);
        write_step(STEP_W'(1));
        run_lines(200);

        drain_points();
        if (n_err == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog
    initial begin
        while (n_cycles < CYCLE_LIMIT) @(posedge i_clk);
        $display("tb: failure");
        $finish;
    end

endmodule
